/* rtl/core/fnfsa_pkg.sv */
`timescale 1ns / 1ps
package fnfsa_pkg;
    localparam int MEM_UNITS    = 65536;
    localparam int MAX_SEGMENTS = 64;
    localparam int BASE_W = 16;
    localparam int LEN_W  = 17;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = IDX_W + 1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADREL = 2'd3;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // One table entry as stored in the segment RAM.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic              used;
    } seg_entry_t;

    localparam int ENTRY_W = $bits(seg_entry_t);
endpackage

/* rtl/core/first_next_fit_segment_allocator.sv */
`timescale 1ns / 1ps
// Operation: an allocate scans segments and, for a split, shifts entries up to open a slot;
// a release scans for the base, then shifts entries down to merge with free neighbours.
// Throughput: one transfer at a time, so an item holds the block until its result is issued;
// the table RAM gives one read per cycle, and that read loop sets the rate.
// Reset: synchronous active-low aresetn; after reset, state S_INIT writes entry 0 (the single
// free segment) before the first request is accepted.
module first_next_fit_segment_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // fit_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,        // req_size[16:0], rel_start[32:17], zero pad
    input  logic        s_tuser,        // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // status[1:0], seg_start[17:2], zero pad
);
    localparam int IW = fnfsa_pkg::IDX_W;
    localparam int CW = fnfsa_pkg::CNT_W;
    localparam int BW = fnfsa_pkg::BASE_W;
    localparam int LW = fnfsa_pkg::LEN_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_SH_RD, S_SH_WR, S_A_WI,
        S_R_RD, S_R_CHK, S_N_RD, S_N_CHK, S_P_RD, S_P_CHK, S_D_RD, S_D_WR, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic             mode_reg, mode_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    rover_reg, rover_next;
    logic [IW-1:0]    first_reg, first_next;
    logic [LW-1:0]    size_reg, size_next;
    logic [BW-1:0]    addr_reg, addr_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [IW-1:0]    drop_reg, drop_next;
    logic             second_reg, second_next;
    logic [BW-1:0]    cur_base_reg, cur_base_next;
    logic [LW-1:0]    cur_len_reg, cur_len_next;
    logic [1:0]       res_st_reg, res_st_next;
    logic [BW-1:0]    res_start_reg, res_start_next;
    logic             m_valid_reg, m_valid_next;
    logic [23:0]      m_data_reg, m_data_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr, ram_raddr;
    fnfsa_pkg::seg_entry_t  ram_wdata, ram_rdata;
    logic [CW-1:0]          pos_sum;
    logic [IW-1:0]          pos;

    fnfsa_ram #(.WIDTH(fnfsa_pkg::ENTRY_W), .DEPTH(fnfsa_pkg::MAX_SEGMENTS)) u_ram (
        .aclk (aclk), .we (ram_we), .waddr (ram_waddr), .wdata (ram_wdata),
        .raddr (ram_raddr), .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Scan position for the allocate search, wrapping once around the table.
    always_comb begin
        pos_sum = {1'b0, first_reg} + k_reg;
        if (pos_sum >= count_reg) begin
            pos_sum = pos_sum - count_reg;
        end
        pos = pos_sum[IW-1:0];
    end

    always_comb begin
        state_next = state_reg;   mode_next = mode_reg;     count_next = count_reg;
        rover_next = rover_reg;   first_next = first_reg;   size_next = size_reg;
        addr_next = addr_reg;     k_next = k_reg;           idx_next = idx_reg;
        j_next = j_reg;           drop_next = drop_reg;     second_next = second_reg;
        cur_base_next = cur_base_reg;  cur_len_next = cur_len_reg;
        res_st_next = res_st_reg;      res_start_next = res_start_reg;
        m_valid_next = m_valid_reg;    m_data_next = m_data_reg;
        ram_we = 1'b0;  ram_waddr = idx_reg;  ram_raddr = pos;
        ram_wdata = '{base: cur_base_reg, len: cur_len_reg, used: 1'b0};

        if (cfg_we) begin
            mode_next = cfg_wdata;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{base: '0, len: LW'(fnfsa_pkg::MEM_UNITS), used: 1'b0};
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    size_next = s_tdata[16:0];
                    addr_next = s_tdata[32:17];
                    k_next = '0;
                    res_start_next = '0;
                    if (s_tuser == fnfsa_pkg::OP_RELEASE) begin
                        state_next = S_R_RD;
                    end else if (s_tdata[16:0] == '0) begin
                        res_st_next = fnfsa_pkg::ST_NOFIT;
                        state_next = S_DONE;
                    end else begin
                        first_next = (mode_reg && ({1'b0, rover_reg} < count_reg)) ?
                                     rover_reg : '0;
                        state_next = S_A_RD;
                    end
                end
            end
            S_A_RD: begin
                ram_raddr = pos;
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                if (!ram_rdata.used && ram_rdata.len >= size_reg) begin
                    cur_base_next = ram_rdata.base;
                    cur_len_next = ram_rdata.len;
                    idx_next = pos;
                    if (ram_rdata.len > size_reg) begin
                        if (count_reg == CW'(fnfsa_pkg::MAX_SEGMENTS)) begin
                            res_st_next = fnfsa_pkg::ST_FULL;
                            state_next = S_DONE;
                        end else begin
                            j_next = count_reg;
                            state_next = S_SH_RD;
                        end
                    end else begin
                        ram_we = 1'b1;
                        ram_waddr = pos;
                        ram_wdata = '{base: ram_rdata.base, len: ram_rdata.len, used: 1'b1};
                        if (mode_reg) begin
                            rover_next = pos;
                        end
                        res_st_next = fnfsa_pkg::ST_OK;
                        res_start_next = ram_rdata.base;
                        state_next = S_DONE;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == count_reg) begin
                        res_st_next = fnfsa_pkg::ST_NOFIT;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_A_RD;
                    end
                end
            end
            S_SH_RD: begin
                // Open a hole at idx+1 by moving entries up, highest first.
                if (j_reg > {1'b0, idx_reg} + 1'b1) begin
                    ram_raddr = IW'(j_reg - 1'b1);
                    state_next = S_SH_WR;
                end else begin
                    ram_we = 1'b1;
                    ram_waddr = idx_reg + 1'b1;
                    ram_wdata = '{base: cur_base_reg + BW'(size_reg),
                                  len: cur_len_reg - size_reg, used: 1'b0};
                    state_next = S_A_WI;
                end
            end
            S_SH_WR: begin
                ram_we = 1'b1;
                ram_waddr = j_reg[IW-1:0];
                ram_wdata = ram_rdata;
                j_next = j_reg - 1'b1;
                state_next = S_SH_RD;
            end
            S_A_WI: begin
                ram_we = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '{base: cur_base_reg, len: size_reg, used: 1'b1};
                count_next = count_reg + 1'b1;
                if (mode_reg) begin
                    rover_next = idx_reg;
                end else if (rover_reg > idx_reg) begin
                    rover_next = rover_reg + 1'b1;
                end
                res_st_next = fnfsa_pkg::ST_OK;
                res_start_next = cur_base_reg;
                state_next = S_DONE;
            end
            S_R_RD: begin
                ram_raddr = k_reg[IW-1:0];
                state_next = S_R_CHK;
            end
            S_R_CHK: begin
                if (ram_rdata.base == addr_reg) begin
                    if (ram_rdata.used) begin
                        idx_next = k_reg[IW-1:0];
                        cur_base_next = ram_rdata.base;
                        cur_len_next = ram_rdata.len;
                        state_next = S_N_RD;
                    end else begin
                        res_st_next = fnfsa_pkg::ST_BADREL;
                        state_next = S_DONE;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == count_reg) begin
                        res_st_next = fnfsa_pkg::ST_BADREL;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_R_RD;
                    end
                end
            end
            S_N_RD: begin
                if ({1'b0, idx_reg} + 1'b1 < count_reg) begin
                    ram_raddr = idx_reg + 1'b1;
                    state_next = S_N_CHK;
                end else begin
                    state_next = S_P_RD;
                end
            end
            S_N_CHK: begin
                if (!ram_rdata.used) begin
                    cur_len_next = cur_len_reg + ram_rdata.len;
                    drop_next = idx_reg + 1'b1;
                    j_next = {1'b0, idx_reg} + 1'b1;
                    second_next = 1'b0;
                    state_next = S_D_RD;
                end else begin
                    state_next = S_P_RD;
                end
            end
            S_P_RD: begin
                if (idx_reg != '0) begin
                    ram_raddr = idx_reg - 1'b1;
                    state_next = S_P_CHK;
                end else begin
                    ram_we = 1'b1;
                    res_st_next = fnfsa_pkg::ST_OK;
                    res_start_next = addr_reg;
                    state_next = S_DONE;
                end
            end
            S_P_CHK: begin
                ram_we = 1'b1;
                if (!ram_rdata.used) begin
                    // The lower free neighbour absorbs this segment.
                    ram_waddr = idx_reg - 1'b1;
                    ram_wdata = '{base: ram_rdata.base, len: ram_rdata.len + cur_len_reg,
                                  used: 1'b0};
                    drop_next = idx_reg;
                    j_next = {1'b0, idx_reg};
                    second_next = 1'b1;
                    state_next = S_D_RD;
                end else begin
                    res_st_next = fnfsa_pkg::ST_OK;
                    res_start_next = addr_reg;
                    state_next = S_DONE;
                end
            end
            S_D_RD: begin
                // Close the gap at drop by moving entries down, lowest first.
                if (j_reg + 1'b1 < count_reg) begin
                    ram_raddr = IW'(j_reg + 1'b1);
                    state_next = S_D_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    if (rover_reg >= drop_reg) begin
                        rover_next = rover_reg - 1'b1;
                    end
                    if (second_reg) begin
                        res_st_next = fnfsa_pkg::ST_OK;
                        res_start_next = addr_reg;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_P_RD;
                    end
                end
            end
            S_D_WR: begin
                ram_we = 1'b1;
                ram_waddr = j_reg[IW-1:0];
                ram_wdata = ram_rdata;
                j_next = j_reg + 1'b1;
                state_next = S_D_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next = {6'd0, res_start_reg, res_st_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            mode_reg    <= 1'b0;
            count_reg   <= CW'(1);
            rover_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            rover_reg   <= rover_next;
            m_valid_reg <= m_valid_next;
        end
        first_reg     <= first_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        k_reg         <= k_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        drop_reg      <= drop_next;
        second_reg    <= second_next;
        cur_base_reg  <= cur_base_next;
        cur_len_reg   <= cur_len_next;
        res_st_reg    <= res_st_next;
        res_start_reg <= res_start_next;
        m_data_reg    <= m_data_next;
    end
endmodule

/* rtl/core/fnfsa_ram.sv */
`timescale 1ns / 1ps
module fnfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
